@@ rtl/dsj_pkg.sv @@
package dsj_pkg;

   localparam int NODE_W = 10;
   localparam int RANK_W = 4;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [RANK_W-1:0] rank_type;

   localparam rank_type RANK_MAX = 4'd15;

   localparam logic FUNC_FIND  = 1'b0;
   localparam logic FUNC_UNION = 1'b1;

   typedef struct packed {
      logic     func;
      node_type node_a;
      node_type node_b;
   } req_type;

   typedef struct packed {
      node_type root;
      logic     merged;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND,
      ST_WALK,
      ST_COMP,
      ST_RANK_A,
      ST_RANK_B,
      ST_LINK,
      ST_DONE
   } state_type;

endpackage

@@ rtl/dsj_ram.sv @@
module dsj_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dsj_seq.sv @@
module dsj_seq #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  dsj_pkg::req_type      req_data,
   output logic                  req_stall,
   input  logic                  out_free,
   output logic                  done,
   output dsj_pkg::rsp_type      res,
   output logic [AW-1:0]         par_rd_addr,
   input  logic [AW-1:0]         par_rd_data,
   output logic                  par_we,
   output logic [AW-1:0]         par_wr_addr,
   output logic [AW-1:0]         par_wr_data,
   output logic [AW-1:0]         rank_rd_addr,
   input  dsj_pkg::rank_type     rank_rd_data,
   output logic                  rank_we,
   output logic [AW-1:0]         rank_wr_addr,
   output dsj_pkg::rank_type     rank_wr_data
);

   localparam logic [dsj_pkg::NODE_W:0] DEPTH_L = (dsj_pkg::NODE_W + 1)'(DEPTH);
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

   dsj_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               func_ff, func_in;
   logic               phase_ff, phase_in;
   dsj_pkg::node_type  b_ff, b_in;
   dsj_pkg::node_type  cur_ff, cur_in;
   dsj_pkg::node_type  start_ff, start_in;
   dsj_pkg::node_type  root_ff, root_in;
   dsj_pkg::node_type  ra_ff, ra_in;
   dsj_pkg::node_type  rb_ff, rb_in;
   dsj_pkg::rank_type  rank_a_ff, rank_a_in;
   dsj_pkg::rsp_type   res_ff, res_in;

   dsj_pkg::node_type  par_node;
   logic               fin;
   dsj_pkg::node_type  fin_root;

   function automatic logic in_range(input dsj_pkg::node_type x);
      return {1'b0, x} < DEPTH_L;
   endfunction

   assign par_node = dsj_pkg::node_type'(par_rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsj_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      func_ff   <= func_in;
      phase_ff  <= phase_in;
      b_ff      <= b_in;
      cur_ff    <= cur_in;
      start_ff  <= start_in;
      root_ff   <= root_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      rank_a_ff <= rank_a_in;
      res_ff    <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      func_in      = func_ff;
      phase_in     = phase_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      root_in      = root_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      rank_a_in    = rank_a_ff;
      res_in       = res_ff;
      req_stall    = 1'b1;
      done         = 1'b0;
      par_rd_addr  = cur_ff[AW-1:0];
      par_we       = 1'b0;
      par_wr_addr  = cur_ff[AW-1:0];
      par_wr_data  = root_ff[AW-1:0];
      rank_rd_addr = ra_ff[AW-1:0];
      rank_we      = 1'b0;
      rank_wr_addr = ra_ff[AW-1:0];
      rank_wr_data = rank_a_ff;
      fin          = 1'b0;
      fin_root     = cur_ff;

      case (state_ff)
         dsj_pkg::ST_CLEAR: begin
            par_we       = 1'b1;
            par_wr_addr  = clr_ff;
            par_wr_data  = clr_ff;
            rank_we      = 1'b1;
            rank_wr_addr = clr_ff;
            rank_wr_data = '0;
            clr_in       = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = dsj_pkg::ST_IDLE;
            end
         end
         dsj_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               func_in  = req_data.func;
               b_in     = req_data.node_b;
               cur_in   = req_data.node_a;
               start_in = req_data.node_a;
               phase_in = 1'b0;
               state_in = dsj_pkg::ST_FIND;
            end
         end
         dsj_pkg::ST_FIND: begin
            if (!in_range(cur_ff)) begin
               fin      = 1'b1;
               fin_root = cur_ff;
            end else begin
               par_rd_addr = cur_ff[AW-1:0];
               state_in    = dsj_pkg::ST_WALK;
            end
         end
         dsj_pkg::ST_WALK: begin
            if (par_node == cur_ff) begin
               if (start_ff == cur_ff) begin
                  fin      = 1'b1;
                  fin_root = cur_ff;
               end else begin
                  root_in     = cur_ff;
                  cur_in      = start_ff;
                  par_rd_addr = start_ff[AW-1:0];
                  state_in    = dsj_pkg::ST_COMP;
               end
            end else begin
               cur_in      = par_node;
               par_rd_addr = par_rd_data;
            end
         end
         dsj_pkg::ST_COMP: begin
            // point this node at the root and follow its old link
            par_we      = 1'b1;
            par_wr_addr = cur_ff[AW-1:0];
            par_wr_data = root_ff[AW-1:0];
            if (par_node == root_ff) begin
               fin      = 1'b1;
               fin_root = root_ff;
            end else begin
               cur_in      = par_node;
               par_rd_addr = par_rd_data;
            end
         end
         dsj_pkg::ST_RANK_A: begin
            rank_rd_addr = ra_ff[AW-1:0];
            state_in     = dsj_pkg::ST_RANK_B;
         end
         dsj_pkg::ST_RANK_B: begin
            rank_rd_addr = rb_ff[AW-1:0];
            rank_a_in    = rank_rd_data;
            state_in     = dsj_pkg::ST_LINK;
         end
         dsj_pkg::ST_LINK: begin
            par_we = 1'b1;
            if (rank_a_ff < rank_rd_data) begin
               par_wr_addr = ra_ff[AW-1:0];
               par_wr_data = rb_ff[AW-1:0];
               res_in      = '{root: rb_ff, merged: 1'b1};
            end else begin
               par_wr_addr = rb_ff[AW-1:0];
               par_wr_data = ra_ff[AW-1:0];
               res_in      = '{root: ra_ff, merged: 1'b1};
               if (rank_a_ff == rank_rd_data && rank_a_ff != dsj_pkg::RANK_MAX) begin
                  rank_we      = 1'b1;
                  rank_wr_addr = ra_ff[AW-1:0];
                  rank_wr_data = rank_a_ff + dsj_pkg::rank_type'(1);
               end
            end
            state_in = dsj_pkg::ST_DONE;
         end
         dsj_pkg::ST_DONE: begin
            done = 1'b1;
            if (out_free) begin
               state_in = dsj_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsj_pkg::ST_IDLE;
         end
      endcase

      if (fin) begin
         if (!phase_ff) begin
            ra_in = fin_root;
            if (func_ff == dsj_pkg::FUNC_UNION) begin
               phase_in = 1'b1;
               cur_in   = b_ff;
               start_in = b_ff;
               state_in = dsj_pkg::ST_FIND;
            end else begin
               res_in   = '{root: fin_root, merged: 1'b0};
               state_in = dsj_pkg::ST_DONE;
            end
         end else begin
            rb_in = fin_root;
            if (in_range(ra_ff) && in_range(fin_root) && ra_ff != fin_root) begin
               state_in = dsj_pkg::ST_RANK_A;
            end else begin
               res_in   = '{root: ra_ff, merged: 1'b0};
               state_in = dsj_pkg::ST_DONE;
            end
         end
      end
   end

   assign res = res_ff;

   a_reset_clears : assert property (@(posedge clock)
      reset |=> state_ff == dsj_pkg::ST_CLEAR)
      else $error("clearing pass not started after reset");

   a_idle_no_write : assert property (@(posedge clock) disable iff (reset)
      state_ff == dsj_pkg::ST_IDLE |-> !par_we && !rank_we)
      else $error("table write while idle");

   a_link_distinct : assert property (@(posedge clock) disable iff (reset)
      state_ff == dsj_pkg::ST_RANK_A |-> ra_ff != rb_ff && in_range(ra_ff) && in_range(rb_ff))
      else $error("linking roots that are equal or outside the table");

   a_done_holds : assert property (@(posedge clock) disable iff (reset)
      state_ff == dsj_pkg::ST_DONE && !out_free |=> state_ff == dsj_pkg::ST_DONE)
      else $error("result dropped while output slot busy");

   a_link_writes : assert property (@(posedge clock) disable iff (reset)
      state_ff == dsj_pkg::ST_LINK |-> par_we && res_in.merged)
      else $error("merge finished without a parent write");

endmodule

@@ rtl/disjoint_set_engine.sv @@
// Union-find engine over NODES nodes (only the first 1024 are addressable). Each
// req word is a find or a union; each gives exactly one rsp word with the root of
// node_a and a merged flag. Parent links and ranks sit in two single-port-read
// synchronous RAMs, and a sequencer walks one link per cycle, so timing depends on
// path length: a find walks up to the root and then compresses the path, and a
// union does both finds, reads both ranks, links the roots if they differ and then
// hands off the result. One operation is in flight at a time; a finished result
// waits in the output register while the next word is taken. After reset the engine
// initializes all min(NODES, 1024) entries of both tables and holds req_stall high
// during that pass.
module disjoint_set_engine #(
   parameter int NODES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsj_pkg::rsp_type rsp_data
);

   localparam int DEPTH = (NODES > (1 << dsj_pkg::NODE_W)) ? (1 << dsj_pkg::NODE_W) : NODES;
   localparam int AW    = $clog2(DEPTH);

   logic              out_free;
   logic              done;
   dsj_pkg::rsp_type  res;
   logic [AW-1:0]     par_rd_addr, par_rd_data, par_wr_addr, par_wr_data;
   logic              par_we;
   logic [AW-1:0]     rank_rd_addr, rank_wr_addr;
   dsj_pkg::rank_type rank_rd_data, rank_wr_data;
   logic              rank_we;

   logic              rsp_valid_ff, rsp_valid_in;
   dsj_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   dsj_seq #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .done        (done),
      .res         (res),
      .par_rd_addr (par_rd_addr),
      .par_rd_data (par_rd_data),
      .par_we      (par_we),
      .par_wr_addr (par_wr_addr),
      .par_wr_data (par_wr_data),
      .rank_rd_addr(rank_rd_addr),
      .rank_rd_data(rank_rd_data),
      .rank_we     (rank_we),
      .rank_wr_addr(rank_wr_addr),
      .rank_wr_data(rank_wr_data)
   );

   dsj_ram #(
      .WIDTH(AW),
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_parent (
      .clock  (clock),
      .wr_en  (par_we),
      .wr_addr(par_wr_addr),
      .wr_data(par_wr_data),
      .rd_addr(par_rd_addr),
      .rd_data(par_rd_data)
   );

   dsj_ram #(
      .WIDTH(dsj_pkg::RANK_W),
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_rank (
      .clock  (clock),
      .wr_en  (rank_we),
      .wr_addr(rank_wr_addr),
      .wr_data(rank_wr_data),
      .rd_addr(rank_rd_addr),
      .rd_data(rank_rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = done;
         if (done) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
